// ===== rtl/bmm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmm_pkg
// Shared types, constants and elaboration-time trigonometry for the button
// mouse motion generator.
// ----------------------------------------------------------------------------
package bmm_pkg;

    localparam int TIME_W      = 32;
    localparam int DBNC_W      = 16;
    localparam int LEVEL_W     = 4;
    localparam int STEP_W      = 4;
    localparam int DELTA_W     = 5;
    localparam int MAX_LEVELS  = 8;
    localparam int MULT_W      = 19;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 16;
    localparam int NUM_ARROWS  = 4;

    localparam int ARROW_UP    = 0;
    localparam int ARROW_DOWN  = 1;
    localparam int ARROW_LEFT  = 2;
    localparam int ARROW_RIGHT = 3;

    localparam int DEF_CIRCLE_RADIUS   = 5;
    localparam int DEF_PHASE_FRAC_BITS = 12;

    localparam logic [DBNC_W-1:0]  RST_ARROW_DBNC   = 16'd50;
    localparam logic [DBNC_W-1:0]  RST_MODE_DBNC    = 16'd200;
    localparam logic [DBNC_W-1:0]  RST_SPEED_STEP   = 16'd500;
    localparam logic [LEVEL_W-1:0] RST_SPEED_LEVELS = 4'd4;

    localparam int THETA_W      = 34;
    localparam int ANGLE_W      = 31;
    localparam int Q30_SHIFT    = 30;
    localparam int QUAD_LIMIT   = 4;
    localparam int SERIES_TERMS = 10;

    localparam longint unsigned ONE_Q30     = 64'd1 << Q30_SHIFT;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    localparam longint unsigned COS_DIV [SERIES_TERMS] =
        '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306, 64'd380};
    localparam longint unsigned SIN_DIV [SERIES_TERMS] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ARROW_DEBOUNCE,
        CFG_MODE_DEBOUNCE,
        CFG_SPEED_STEP,
        CFG_SPEED_LEVELS
    } t_cfg_reg;

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } t_quadrant;

    typedef struct packed {
        logic [DBNC_W-1:0]  debounce;
        logic [DBNC_W-1:0]  step_ms;
        logic [LEVEL_W-1:0] levels;
    } t_arrow_cfg;

    typedef struct packed {
        logic              pressed;
        logic [STEP_W-1:0] step;
    } t_lane_out;

    // Taylor series of cos (even) or sin (odd) in Q30 for 0 <= r < pi/2.
    function automatic longint signed bmm_series(longint unsigned r, bit odd);
        longint unsigned t;
        longint signed   sum;
        bit              neg;
        t   = odd ? r : ONE_Q30;
        sum = 0;
        neg = 1'b0;
        for (int i = 0; i < SERIES_TERMS; i++) begin
            sum = neg ? sum - signed'(t) : sum + signed'(t);
            t   = (t * r) >> Q30_SHIFT;
            t   = (t * r) >> Q30_SHIFT;
            t   = odd ? t / SIN_DIV[i] : t / COS_DIV[i];
            neg = !neg;
        end
        return sum;
    endfunction

    // Number of breakpoints passed by a Q30 value at the given radius.
    function automatic int bmm_scale(longint signed v, int radius);
        longint unsigned m;
        longint unsigned k;
        m = (v < 0) ? unsigned'(-v) : unsigned'(v);
        if (m > ONE_Q30) begin
            m = ONE_Q30;
        end
        k = (64'(radius) * m) >> Q30_SHIFT;
        if (k > 64'(radius)) begin
            k = 64'(radius);
        end
        return int'(k);
    endfunction

    // Largest reduced angle whose cosine still reaches breakpoint k.
    function automatic longint unsigned bmm_cos_thresh(int radius, int k);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        lo = 0;
        hi = HALF_PI_Q30 - 1;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (bmm_scale(bmm_series(mid, 1'b0), radius) >= k) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return lo;
    endfunction

    // Smallest reduced angle whose sine reaches breakpoint k.
    function automatic longint unsigned bmm_sin_thresh(int radius, int k);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        lo = 0;
        hi = HALF_PI_Q30;
        while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (bmm_scale(bmm_series(mid, 1'b1), radius) >= k) begin
                hi = mid;
            end else begin
                lo = mid + 1;
            end
        end
        return lo;
    endfunction

endpackage

// ===== rtl/bmm_arrow_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmm_arrow_lane
// One arrow button: debouncer, press time stamp and accelerated step size.
// ----------------------------------------------------------------------------
module bmm_arrow_lane
    import bmm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [TIME_W-1:0] i_now,
    input  logic              i_raw,
    input  t_arrow_cfg        i_cfg,
    output t_lane_out         o_lane
);

    logic              r_last;
    logic              r_pressed;
    logic [TIME_W-1:0] r_chg;
    logic [TIME_W-1:0] r_start;
    logic              n_pressed;
    logic [TIME_W-1:0] n_chg;
    logic [TIME_W-1:0] n_start;
    logic              w_accept;
    logic [TIME_W-1:0] w_hold;
    logic [STEP_W-1:0] w_speed;

    always_comb begin
        n_chg     = (i_raw != r_last) ? i_now : r_chg;
        w_accept  = (i_raw == r_last) && ((i_now - r_chg) > TIME_W'(i_cfg.debounce));
        n_pressed = w_accept ? i_raw : r_pressed;
        n_start   = r_start;
        if (w_accept && !i_raw) begin
            n_start = '0;
        end else if (w_accept && i_raw && !r_pressed) begin
            n_start = i_now;
        end
        w_hold  = i_now - n_start;
        w_speed = '0;
        for (int k = 1; k < MAX_LEVELS; k++) begin
            if ((LEVEL_W'(k) < i_cfg.levels) &&
                (w_hold >= TIME_W'(MULT_W'(i_cfg.step_ms) * MULT_W'(k)))) begin
                w_speed = w_speed + STEP_W'(1);
            end
        end
        o_lane.pressed = n_pressed;
        o_lane.step    = w_speed + STEP_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last    <= 1'b0;
            r_pressed <= 1'b0;
            r_chg     <= '0;
            r_start   <= '0;
        end else if (i_en) begin
            r_last    <= i_raw;
            r_pressed <= n_pressed;
            r_chg     <= n_chg;
            r_start   <= n_start;
        end
    end

endmodule

// ===== rtl/bmm_circle.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmm_circle
// Circle generator: phase accumulator, quadrant reduction and breakpoint
// compares that give the truncated radius times cosine and sine.
// ----------------------------------------------------------------------------
module bmm_circle
    import bmm_pkg::*;
#(
    parameter int CIRCLE_RADIUS   = DEF_CIRCLE_RADIUS,
    parameter int PHASE_FRAC_BITS = DEF_PHASE_FRAC_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_adv,
    output logic signed [DELTA_W-1:0] o_dx,
    output logic signed [DELTA_W-1:0] o_dy
);

    localparam int              SHIFT      = Q30_SHIFT - PHASE_FRAC_BITS;
    localparam longint unsigned PHASE_WRAP =
        ((64'd6283185307 << PHASE_FRAC_BITS) + 64'd500000000) / 64'd1000000000;
    localparam longint unsigned PHASE_STEP = ((64'd1 << PHASE_FRAC_BITS) + 64'd5) / 64'd10;
    localparam int              PW         = $clog2(PHASE_WRAP);

    logic [PW-1:0]        r_phase;
    logic [PW:0]          w_sum;
    logic [PW-1:0]        w_adv_phase;
    logic [THETA_W-1:0]   w_theta;
    logic [THETA_W-1:0]   w_base;
    logic [1:0]           w_q;
    logic [ANGLE_W-1:0]   w_r;
    logic [CIRCLE_RADIUS-1:0] w_cos_hit;
    logic [CIRCLE_RADIUS-1:0] w_sin_hit;
    logic [STEP_W-1:0]    w_c_cnt;
    logic [STEP_W-1:0]    w_s_cnt;
    logic signed [DELTA_W-1:0] w_c_pos;
    logic signed [DELTA_W-1:0] w_s_pos;

    always_comb begin
        w_sum = {1'b0, r_phase} + (PW + 1)'(PHASE_STEP);
        if (w_sum >= (PW + 1)'(PHASE_WRAP)) begin
            w_adv_phase = PW'(w_sum - (PW + 1)'(PHASE_WRAP));
        end else begin
            w_adv_phase = w_sum[PW-1:0];
        end
        w_theta = THETA_W'(w_adv_phase) << SHIFT;
        w_q     = '0;
        w_base  = '0;
        for (int m = 1; m < QUAD_LIMIT; m++) begin
            if (w_theta >= THETA_W'(HALF_PI_Q30 * 64'(m))) begin
                w_q    = 2'(m);
                w_base = THETA_W'(HALF_PI_Q30 * 64'(m));
            end
        end
        w_r = ANGLE_W'(w_theta - w_base);
    end

    for (genvar k = 0; k < CIRCLE_RADIUS; k++) begin : g_brk
        localparam logic [ANGLE_W-1:0] COS_TH = ANGLE_W'(bmm_cos_thresh(CIRCLE_RADIUS, k + 1));
        localparam logic [ANGLE_W-1:0] SIN_TH = ANGLE_W'(bmm_sin_thresh(CIRCLE_RADIUS, k + 1));
        assign w_cos_hit[k] = (w_r <= COS_TH);
        assign w_sin_hit[k] = (w_r >= SIN_TH);
    end

    always_comb begin
        w_c_cnt = '0;
        w_s_cnt = '0;
        for (int k = 0; k < CIRCLE_RADIUS; k++) begin
            w_c_cnt = w_c_cnt + STEP_W'(w_cos_hit[k]);
            w_s_cnt = w_s_cnt + STEP_W'(w_sin_hit[k]);
        end
        w_c_pos = $signed({1'b0, w_c_cnt});
        w_s_pos = $signed({1'b0, w_s_cnt});
        case (t_quadrant'(w_q))
            QUAD_0: begin
                o_dx = w_c_pos;
                o_dy = w_s_pos;
            end
            QUAD_1: begin
                o_dx = -w_s_pos;
                o_dy = w_c_pos;
            end
            QUAD_2: begin
                o_dx = -w_c_pos;
                o_dy = -w_s_pos;
            end
            QUAD_3: begin
                o_dx = w_s_pos;
                o_dy = -w_c_pos;
            end
            default: begin
                o_dx = '0;
                o_dy = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_adv) begin
            r_phase <= w_adv_phase;
        end
    end

endmodule

// ===== rtl/bmm_out_skid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmm_out_skid
// Two-entry output buffer: a result register and a skid register, so the
// input side stays ready while one result waits to be taken.
// ----------------------------------------------------------------------------
module bmm_out_skid
    import bmm_pkg::*;
#(
    parameter int WIDTH = OUT_TDATA_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    logic             r_main_valid;
    logic             r_skid_valid;
    logic [WIDTH-1:0] r_main;
    logic [WIDTH-1:0] r_skid;
    logic             n_main_valid;
    logic             n_skid_valid;
    logic [WIDTH-1:0] n_main;
    logic [WIDTH-1:0] n_skid;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (i_ready) begin
                n_main       = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_valid) begin
            if (!r_main_valid || i_ready) begin
                n_main       = i_data;
                n_main_valid = 1'b1;
            end else begin
                n_skid       = i_data;
                n_skid_valid = 1'b1;
            end
        end else if (i_ready) begin
            n_main_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

endmodule

// ===== rtl/button_mouse_motion_generator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_mouse_motion_generator_top
// Debounced five-button mouse: mode toggle, accelerated arrow steps in four
// parallel lanes and a circle generator in remote mode.
// ----------------------------------------------------------------------------
// Channel   Direction  Width  Handshake
// s (poll)  in         40     i_s_tvalid / o_s_tready
// m (move)  out        16     o_m_tvalid / i_m_tready
// cfg       in         2+16   i_cfg_valid / o_cfg_ready
//
// One poll word is accepted per cycle while o_s_tready is high; the mode
// debouncer and the arrow lanes (local) or the circle unit (remote) update
// their state in the accepting cycle; results are registered in the buffer.
// A two-entry output buffer keeps o_s_tready high while one result waits.
// Polls with host_ready low are accepted and give no word.
// Reset is synchronous; the configuration port is always ready.
// ----------------------------------------------------------------------------
module button_mouse_motion_generator_top
    import bmm_pkg::*;
#(
    parameter int CIRCLE_RADIUS   = DEF_CIRCLE_RADIUS,
    parameter int PHASE_FRAC_BITS = DEF_PHASE_FRAC_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // now_ms[31:0], host_ready[32], mode_pin[33], up_pin[34], down_pin[35],
    // left_pin[36], right_pin[37], zero[39:38]
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // delta_x[4:0], delta_y[9:5], remote_mode[10], zero[15:11]
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic [DBNC_W-1:0]  r_arrow_dbnc;
    logic [DBNC_W-1:0]  r_mode_dbnc;
    logic [DBNC_W-1:0]  r_speed_step;
    logic [LEVEL_W-1:0] r_speed_levels;

    logic              r_mode_last;
    logic              r_mode_pressed;
    logic [TIME_W-1:0] r_mode_chg;
    logic              r_mode_flag;
    logic              n_mode_pressed;
    logic [TIME_W-1:0] n_mode_chg;
    logic              n_mode_flag;
    logic              w_mode_accept;

    logic [TIME_W-1:0]     w_now;
    logic                  w_mode_raw;
    logic [NUM_ARROWS-1:0] w_arrow_raw;
    logic                  w_poll;
    logic [LEVEL_W-1:0]    w_levels;
    t_arrow_cfg            w_arrow_cfg;
    t_lane_out             w_lane [NUM_ARROWS];

    logic signed [DELTA_W-1:0] w_arrow_dx;
    logic signed [DELTA_W-1:0] w_arrow_dy;
    logic signed [DELTA_W-1:0] w_circ_dx;
    logic signed [DELTA_W-1:0] w_circ_dy;
    logic signed [DELTA_W-1:0] w_dx;
    logic signed [DELTA_W-1:0] w_dy;
    logic [OUT_TDATA_W-1:0]    w_out_word;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arrow_dbnc   <= RST_ARROW_DBNC;
            r_mode_dbnc    <= RST_MODE_DBNC;
            r_speed_step   <= RST_SPEED_STEP;
            r_speed_levels <= RST_SPEED_LEVELS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_ARROW_DEBOUNCE: r_arrow_dbnc   <= i_cfg_data;
                CFG_MODE_DEBOUNCE:  r_mode_dbnc    <= i_cfg_data;
                CFG_SPEED_STEP:     r_speed_step   <= i_cfg_data;
                CFG_SPEED_LEVELS:   r_speed_levels <= i_cfg_data[LEVEL_W-1:0];
                default:            r_speed_levels <= r_speed_levels;
            endcase
        end
    end

    assign w_now          = i_s_tdata[TIME_W-1:0];
    assign w_poll         = i_s_tvalid && o_s_tready && i_s_tdata[TIME_W];
    assign w_mode_raw     = !i_s_tdata[TIME_W+1];
    assign w_arrow_raw    = ~i_s_tdata[TIME_W+2 +: NUM_ARROWS];

    always_comb begin
        n_mode_chg     = (w_mode_raw != r_mode_last) ? w_now : r_mode_chg;
        w_mode_accept  = (w_mode_raw == r_mode_last) &&
                         ((w_now - r_mode_chg) > TIME_W'(r_mode_dbnc));
        n_mode_pressed = w_mode_accept ? w_mode_raw : r_mode_pressed;
        n_mode_flag    = r_mode_flag ^ (w_mode_accept && w_mode_raw && !r_mode_pressed);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_last    <= 1'b0;
            r_mode_pressed <= 1'b0;
            r_mode_chg     <= '0;
            r_mode_flag    <= 1'b0;
        end else if (w_poll) begin
            r_mode_last    <= w_mode_raw;
            r_mode_pressed <= n_mode_pressed;
            r_mode_chg     <= n_mode_chg;
            r_mode_flag    <= n_mode_flag;
        end
    end

    always_comb begin
        if (r_speed_levels == '0) begin
            w_levels = LEVEL_W'(1);
        end else if (r_speed_levels > LEVEL_W'(MAX_LEVELS)) begin
            w_levels = LEVEL_W'(MAX_LEVELS);
        end else begin
            w_levels = r_speed_levels;
        end
        w_arrow_cfg.debounce = r_arrow_dbnc;
        w_arrow_cfg.step_ms  = r_speed_step;
        w_arrow_cfg.levels   = w_levels;
    end

    for (genvar i = 0; i < NUM_ARROWS; i++) begin : g_lane
        bmm_arrow_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_poll && !n_mode_flag),
            .i_now   (w_now),
            .i_raw   (w_arrow_raw[i]),
            .i_cfg   (w_arrow_cfg),
            .o_lane  (w_lane[i])
        );
    end

    bmm_circle #(
        .CIRCLE_RADIUS   (CIRCLE_RADIUS),
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
    ) u_circle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_poll && n_mode_flag),
        .o_dx    (w_circ_dx),
        .o_dy    (w_circ_dy)
    );

    // Down overrides up and right overrides left.
    always_comb begin
        w_arrow_dy = '0;
        w_arrow_dx = '0;
        if (w_lane[ARROW_DOWN].pressed) begin
            w_arrow_dy = $signed({1'b0, w_lane[ARROW_DOWN].step});
        end else if (w_lane[ARROW_UP].pressed) begin
            w_arrow_dy = -$signed({1'b0, w_lane[ARROW_UP].step});
        end
        if (w_lane[ARROW_RIGHT].pressed) begin
            w_arrow_dx = $signed({1'b0, w_lane[ARROW_RIGHT].step});
        end else if (w_lane[ARROW_LEFT].pressed) begin
            w_arrow_dx = -$signed({1'b0, w_lane[ARROW_LEFT].step});
        end
        w_dx       = n_mode_flag ? w_circ_dx : w_arrow_dx;
        w_dy       = n_mode_flag ? w_circ_dy : w_arrow_dy;
        w_out_word = {5'b0, n_mode_flag, w_dy, w_dx};
    end

    bmm_out_skid #(
        .WIDTH (OUT_TDATA_W)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_poll),
        .o_ready (o_s_tready),
        .i_data  (w_out_word),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (o_m_tdata)
    );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the button mouse motion generator. Polls carry a
// time line with held, released and bouncing buttons, host-not-ready polls
// and pure noise. A scoreboard predicts every move word from its own model of
// the debouncers, the arrow acceleration and the circle generator, and checks
// each word leaving the block. Several register settings, the extremes among
// them, run under different sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb;
    import bmm_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 300;

    localparam int POS_READY  = 32;
    localparam int POS_MODE   = 33;
    localparam int POS_ARROW0 = 34;

    localparam logic [4:0] ALL_RELEASED = 5'b11111;

    // The phase is kept in units of 2^-12 radians, the block's default.
    localparam int              PHASE_ADVANCE = 410;
    localparam int              PHASE_WRAP    = 25736;
    localparam int              PHASE_SHIFT   = 18;
    localparam longint unsigned Q30_ONE       = 64'd1 << 30;
    localparam longint unsigned Q30_HALF_PI   = 64'd1686629713;
    localparam longint unsigned RADIUS        = 64'd5;

    class motion_scoreboard;
        logic [15:0] arrow_db;
        logic [15:0] mode_db;
        logic [15:0] step_ms;
        logic [3:0]  levels;

        bit          remote;
        bit          mode_last;
        bit          mode_held;
        logic [31:0] mode_chg;
        bit          arrow_last [NUM_ARROWS];
        bit          arrow_held [NUM_ARROWS];
        logic [31:0] arrow_chg [NUM_ARROWS];
        logic [31:0] arrow_start [NUM_ARROWS];
        int          phase;

        logic [15:0] move_q [$];
        int          errors;
        int          polls;
        int          idle_polls;
        int          moves;
        int          remote_moves;
        int          wraps;

        function new();
            arrow_db  = 16'd50;
            mode_db   = 16'd200;
            step_ms   = 16'd500;
            levels    = 4'd4;
            remote    = 1'b0;
            mode_last = 1'b0;
            mode_held = 1'b0;
            mode_chg  = '0;
            for (int i = 0; i < NUM_ARROWS; i++) begin
                arrow_last[i]  = 1'b0;
                arrow_held[i]  = 1'b0;
                arrow_chg[i]   = '0;
                arrow_start[i] = '0;
            end
            phase        = 0;
            errors       = 0;
            polls        = 0;
            idle_polls   = 0;
            moves        = 0;
            remote_moves = 0;
            wraps        = 0;
        endfunction

        function void set_reg(t_cfg_reg idx, logic [15:0] d);
            case (idx)
                CFG_ARROW_DEBOUNCE: arrow_db = d;
                CFG_MODE_DEBOUNCE:  mode_db  = d;
                CFG_SPEED_STEP:     step_ms  = d;
                CFG_SPEED_LEVELS:   levels   = d[3:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return move_q.size();
        endfunction

        function bit debounce(input logic [31:0] now, input bit raw, input logic [31:0] lim,
                              inout bit last, inout bit held, inout logic [31:0] chg);
            bit rise;
            rise = 1'b0;
            if (raw != last) chg = now;
            if ((now - chg) > lim) begin
                rise = raw && !held;
                held = raw;
            end
            last = raw;
            return rise;
        endfunction

        function int arrow_step(logic [31:0] now, int idx);
            logic [31:0] lv;
            logic [31:0] hold;
            logic [31:0] speed;
            lv = {28'b0, levels};
            if (lv == 0) lv = 1;
            if (lv > MAX_LEVELS) lv = MAX_LEVELS;
            hold  = now - arrow_start[idx];
            speed = (step_ms != 0) ? hold / {16'b0, step_ms} : 32'hFFFF_FFFF;
            if (speed >= lv) speed = lv - 1;
            return int'(speed) + 1;
        endfunction

        function longint signed trig_q30(longint unsigned r, bit odd);
            longint unsigned t;
            longint unsigned n;
            longint signed   acc;
            bit              neg;
            t   = odd ? r : Q30_ONE;
            n   = odd ? 1 : 0;
            acc = 0;
            neg = 1'b0;
            for (int i = 0; i < 10; i++) begin
                if (neg) acc = acc - $signed(t);
                else acc = acc + $signed(t);
                t   = (t * r) >> 30;
                t   = (t * r) >> 30;
                t   = t / ((n + 1) * (n + 2));
                n   = n + 2;
                neg = !neg;
            end
            return acc;
        endfunction

        function int to_steps(longint signed v);
            longint unsigned m;
            longint unsigned k;
            m = (v < 0) ? -v : v;
            if (m > Q30_ONE) m = Q30_ONE;
            k = (RADIUS * m) >> 30;
            if (k > RADIUS) k = RADIUS;
            return (v < 0) ? -int'(k) : int'(k);
        endfunction

        function void note_poll(logic [IN_TDATA_W-1:0] w);
            logic [31:0]     now;
            int              dx;
            int              dy;
            bit              r;
            bit              was;
            longint unsigned th;
            longint unsigned q;
            longint unsigned rem;
            longint signed   c;
            longint signed   s;
            longint signed   cv;
            longint signed   sv;
            logic [4:0]      dx5;
            logic [4:0]      dy5;
            now = w[31:0];
            dx  = 0;
            dy  = 0;
            polls++;
            if (!w[POS_READY]) begin
                idle_polls++;
                return;
            end
            if (debounce(now, !w[POS_MODE], {16'b0, mode_db}, mode_last, mode_held, mode_chg))
                remote = !remote;
            if (!remote) begin
                for (int i = 0; i < NUM_ARROWS; i++) begin
                    r   = !w[POS_ARROW0 + i];
                    was = arrow_held[i];
                    if (debounce(now, r, {16'b0, arrow_db}, arrow_last[i], arrow_held[i],
                                 arrow_chg[i]))
                        arrow_start[i] = now;
                    else if (was != arrow_held[i] && !arrow_held[i])
                        arrow_start[i] = '0;
                    else if (!arrow_held[i] && !r && (now - arrow_chg[i]) > {16'b0, arrow_db})
                        arrow_start[i] = '0;
                end
                if (arrow_held[ARROW_UP])    dy = -arrow_step(now, ARROW_UP);
                if (arrow_held[ARROW_DOWN])  dy = arrow_step(now, ARROW_DOWN);
                if (arrow_held[ARROW_LEFT])  dx = -arrow_step(now, ARROW_LEFT);
                if (arrow_held[ARROW_RIGHT]) dx = arrow_step(now, ARROW_RIGHT);
            end else begin
                phase = phase + PHASE_ADVANCE;
                if (phase >= PHASE_WRAP) begin
                    phase = phase - PHASE_WRAP;
                    wraps++;
                end
                th  = longint'(phase);
                th  = th << PHASE_SHIFT;
                q   = th / Q30_HALF_PI;
                rem = th - q * Q30_HALF_PI;
                c   = trig_q30(rem, 1'b0);
                s   = trig_q30(rem, 1'b1);
                case (t_quadrant'(q[1:0]))
                    QUAD_0: begin
                        cv = c;
                        sv = s;
                    end
                    QUAD_1: begin
                        cv = -s;
                        sv = c;
                    end
                    QUAD_2: begin
                        cv = -c;
                        sv = -s;
                    end
                    default: begin
                        cv = s;
                        sv = -c;
                    end
                endcase
                dx = to_steps(cv);
                dy = to_steps(sv);
                remote_moves++;
            end
            dx5 = dx[4:0];
            dy5 = dy[4:0];
            move_q.push_back({5'b0, remote, dy5, dx5});
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40) $display("MISMATCH: %s", msg);
        endtask

        task check_move(logic [OUT_TDATA_W-1:0] got);
            logic [15:0] want;
            if (move_q.size() == 0) begin
                report($sformatf("move word %h arrived with no poll waiting", got));
                return;
            end
            want = move_q.pop_front();
            moves++;
            if (got[4:0] !== want[4:0])
                report($sformatf("move %0d delta_x got %0d want %0d", moves,
                                 $signed(got[4:0]), $signed(want[4:0])));
            if (got[9:5] !== want[9:5])
                report($sformatf("move %0d delta_y got %0d want %0d", moves,
                                 $signed(got[9:5]), $signed(want[9:5])));
            if (got[10] !== want[10])
                report($sformatf("move %0d remote_mode got %b want %b", moves,
                                 got[10], want[10]));
            if (got[15:11] !== want[15:11])
                report($sformatf("move %0d padding got %b", moves, got[15:11]));
        endtask
    endclass

    logic                   i_clk;
    logic                   i_rst_n     = 1'b0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata   = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    t_cfg_reg               i_cfg_index = CFG_ARROW_DEBOUNCE;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;

    button_mouse_motion_generator_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    motion_scoreboard sb = new();

    int          idle_pct   = 0;
    int          stall_pct  = 0;
    bit          hold_req   = 1'b0;
    bit          hold_seen  = 1'b0;
    int          hold_left  = 0;
    int          cycles     = 0;
    int          settings   = 0;
    logic [31:0] gen_ms     = '0;
    logic [4:0]  gen_pins   = ALL_RELEASED;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen  <= hold_req;
            hold_left  <= HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.set_reg(i_cfg_index, i_cfg_data);
            if (i_s_tvalid && o_s_tready) sb.note_poll(i_s_tdata);
            if (o_m_tvalid && i_m_tready) sb.check_move(o_m_tdata);
        end
    end

    function logic [IN_TDATA_W-1:0] poll_word(logic [31:0] now, bit ready, logic [4:0] pins);
        return {2'b00, pins, ready, now};
    endfunction

    task send_poll(logic [IN_TDATA_W-1:0] w);
        int gaps;
        gaps = 0;
        while (idle_pct > 0 && gaps < 12 && $urandom_range(0, 99) < idle_pct) gaps++;
        if (gaps > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gaps) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= w;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task write_reg(t_cfg_reg idx, logic [15:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task apply_settings(logic [15:0] adb, logic [15:0] mdb, logic [15:0] stp,
                        logic [15:0] lvl);
        drain();
        repeat (4) @(posedge i_clk);
        write_reg(CFG_ARROW_DEBOUNCE, adb);
        write_reg(CFG_MODE_DEBOUNCE, mdb);
        write_reg(CFG_SPEED_STEP, stp);
        write_reg(CFG_SPEED_LEVELS, lvl);
        i_cfg_valid <= 1'b0;
        settings++;
    endtask

    task rand_poll(output bit rdy);
        int          roll;
        logic [31:0] span;
        logic [31:0] dt;
        logic [31:0] now_v;
        logic [4:0]  pv;
        roll = $urandom_range(0, 99);
        span = {16'b0, sb.arrow_db};
        if (sb.mode_db > span) span = {16'b0, sb.mode_db};
        if (sb.step_ms > span) span = {16'b0, sb.step_ms};
        if (roll < 8) begin
            now_v = $urandom;
            pv    = 5'($urandom);
            rdy   = 1'($urandom);
        end else begin
            if (roll < 23) dt = $urandom_range(0, span * 3 + 2);
            else dt = $urandom_range(0, span / 8 + 2);
            gen_ms = gen_ms + dt;
            for (int i = 1; i < 5; i++) begin
                if ($urandom_range(0, 15) == 0) gen_pins[i] = ~gen_pins[i];
            end
            if ($urandom_range(0, 19) == 0) gen_pins[0] = ~gen_pins[0];
            now_v = gen_ms;
            pv    = gen_pins;
            rdy   = ($urandom_range(0, 9) != 0);
        end
        send_poll(poll_word(now_v, rdy, pv));
    endtask

    task run_random(int n, int sidle, int rstall, int hold_at, int pause_at);
        int count;
        bit rdy;
        count     = 0;
        idle_pct  = sidle;
        stall_pct <= rstall;
        if ($urandom_range(0, 2) == 0) gen_ms = 32'hFFFF_0000 + $urandom_range(0, 65535);
        while (count < n) begin
            if (count == hold_at) hold_req <= ~hold_req;
            if (count == pause_at) drain();
            rand_poll(rdy);
            if (rdy) count++;
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_poll(poll_word(32'd0, 1'b0, 5'b00000));
        send_poll(poll_word(32'd0, 1'b1, ALL_RELEASED));
        send_poll(poll_word(32'hFFFF_FFFF, 1'b1, ALL_RELEASED));
        send_poll(poll_word(32'd1000, 1'b1, 5'b11101));
        send_poll(poll_word(32'd1050, 1'b1, 5'b11101));
        send_poll(poll_word(32'd1051, 1'b1, 5'b11101));
        send_poll(poll_word(32'd1551, 1'b1, 5'b11101));
        send_poll(poll_word(32'd9999, 1'b1, 5'b11101));
        send_poll(poll_word(32'd10000, 1'b1, 5'b10101));
        send_poll(poll_word(32'd10051, 1'b1, 5'b10101));
        send_poll(poll_word(32'd10060, 1'b1, 5'b00001));
        send_poll(poll_word(32'd10111, 1'b1, 5'b00001));
        send_poll(poll_word(32'd10200, 1'b1, ALL_RELEASED));
        send_poll(poll_word(32'd10251, 1'b1, ALL_RELEASED));
        send_poll(poll_word(32'd20000, 1'b1, 5'b11110));
        send_poll(poll_word(32'd20200, 1'b1, 5'b11110));
        send_poll(poll_word(32'd20201, 1'b1, 5'b11110));
        send_poll(poll_word(32'd20202, 1'b1, 5'b00000));
        send_poll(poll_word(32'd20300, 1'b1, ALL_RELEASED));
        send_poll(poll_word(32'd20501, 1'b1, ALL_RELEASED));
        send_poll(poll_word(32'd20600, 1'b1, 5'b11110));
        send_poll(poll_word(32'd20801, 1'b1, 5'b11110));
        send_poll(poll_word(32'hFFFF_FFF0, 1'b1, 5'b01110));
        send_poll(poll_word(32'h0000_0030, 1'b1, 5'b01110));
        send_poll(poll_word(32'h0001_0000, 1'b0, 5'b10101));

        apply_settings(16'd50, 16'd200, 16'd500, 16'd4);
        run_random(150, 0, 0, 60, -1);
        apply_settings(16'd0, 16'd0, 16'd1, 16'd8);
        run_random(130, 57, 0, -1, -1);
        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1);
        run_random(130, 0, 57, -1, -1);
        apply_settings(16'd10, 16'd30, 16'd7, 16'd8);
        run_random(150, 36, 36, -1, 75);
        apply_settings(16'd0, 16'hFFFF, 16'd0, 16'd15);
        run_random(110, 0, 0, -1, -1);
        apply_settings(16'hFFFF, 16'd0, 16'd100, 16'd0);
        run_random(110, 57, 0, -1, -1);
        apply_settings(16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)),
                       16'($urandom_range(1, 300)), 16'($urandom_range(0, 65535)));
        run_random(160, 36, 36, 40, 120);
        apply_settings(16'd20, 16'd40, 16'd60, 16'd3);
        run_random(130, 0, 57, -1, -1);

        drain();
        repeat (10) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d move words never arrived", sb.pending()));
        $display("Covered %0d polls (%0d with host not ready) under %0d register settings.",
                 sb.polls, sb.idle_polls, settings);
        $display("Checked %0d move words, %0d in remote mode, circle wrapped %0d times.",
                 sb.moves, sb.remote_moves, sb.wraps);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== button_mouse_motion_generator_top.f =====
rtl/bmm_pkg.sv
rtl/bmm_arrow_lane.sv
rtl/bmm_circle.sv
rtl/bmm_out_skid.sv
rtl/button_mouse_motion_generator_top.sv
test/tb.sv
